// File: design/three_border_color_map_macros.svh
// assertion macros for the three border color map
// expects clk and rst_n in the scope of use
`ifndef THREE_BORDER_COLOR_MAP_MACROS_SVH
`define THREE_BORDER_COLOR_MAP_MACROS_SVH

// property must hold at every clock edge out of reset
`define CBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define CBM_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: design/cbm_pkg.sv
// shared constants, codes and payload types of the three border color map
// no dependencies
`default_nettype none

package cbm_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int SAMPLE_W   = 16;
  localparam int COLOR_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // weight numerator and denominator
  localparam int NUM_W  = SAMPLE_W + 1;
  localparam int DEN_W  = SAMPLE_W;
  // divider: dividend num*c*2+den, divisor 2*den
  localparam int DIVD_W = NUM_W + 8 + 1;
  localparam int DIVS_W = DEN_W + 1;
  localparam int Q_W    = 8;
  // square root of a 32 bit radicand
  localparam int RAD_W  = 2 * SAMPLE_W;
  localparam int ROOT_W = SAMPLE_W;
  localparam int SREM_W = ROOT_W + 3;

  localparam int STEPS_PER_STG = 2;
  localparam int CORE_STG      = DIVD_W / STEPS_PER_STG;
  localparam int SQRT_STG      = ROOT_W / STEPS_PER_STG;

  localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;
  localparam longint unsigned CQ    = (33 * ONE_Q + 50) / 100;
  localparam longint unsigned KQ    = (6715 * ONE_Q + 5000) / 10000;
  localparam longint unsigned ONE2  = 64'd1 << (2 * FRAC_BITS);
  localparam longint unsigned HALF3 = 3 * (64'd1 << (2 * FRAC_BITS - 1));

  localparam int P_W      = FRAC_BITS + ROOT_W;
  localparam int G_W      = 2 * FRAC_BITS + 1;
  localparam int SUM_W    = 10;
  localparam int PROD_W   = G_W + SUM_W;
  localparam int T_W      = 11;
  localparam int RECIP_SH = 11;
  localparam int RECIP3   = 683;
  localparam int M_W      = T_W + RECIP_SH;

  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_MID  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MID   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_HIGH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BUMP_ENABLE = 3'd6;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] border_low;
    logic signed [SAMPLE_W-1:0] border_mid;
    logic signed [SAMPLE_W-1:0] border_high;
    logic [COLOR_W-1:0]         color_low;
    logic [COLOR_W-1:0]         color_mid;
    logic [COLOR_W-1:0]         color_high;
    logic                       bump_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    border_low:  -16'sd8192,
    border_mid:  16'sd0,
    border_high: 16'sd8192,
    color_low:   24'h000000,
    color_mid:   24'h808080,
    color_high:  24'hFFFFFF,
    bump_enable: 1'b0
  };

  // index order: weight low, mid, high; channel red, green, blue
  typedef struct packed {
    logic [2:0][2:0][DIVD_W-1:0] x;
    logic [2:0][DIVS_W-1:0]      y;
    logic [RAD_W-1:0]            a2;
    logic [RAD_W-1:0]            b2;
  } prep_t;

  typedef struct packed {
    logic [2:0][2:0][DIVD_W-1:0] xs;
    logic [2:0][2:0][DIVS_W-1:0] rem;
    logic [2:0][2:0][Q_W-1:0]    q;
    logic [2:0][DIVS_W-1:0]      y;
    logic [RAD_W-1:0]            vs;
    logic [SREM_W-1:0]           srem;
    logic [ROOT_W-1:0]           root;
  } core_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] gray;
  } pix_t;

endpackage

`default_nettype wire

// File: design/cbm_stream_if.sv
// valid/ready stream interfaces for noise samples and pixels
// depends on cbm_pkg
`default_nettype none

interface cbm_in_if import cbm_pkg::*; ;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] noise_sample;

  modport source (output valid, output noise_sample, input ready);
  modport sink (input valid, input noise_sample, output ready);
endinterface

interface cbm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] gray;

  modport source (output valid, output red, output green, output blue, output gray,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input gray,
                output ready);
endinterface

`default_nettype wire

// File: design/cbm_prep.sv
// front stages: weight numerators and denominators, dividends, squared distances
// depends on cbm_pkg
`default_nettype none

module cbm_prep import cbm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  cfg_t                       cfg,
  output logic                       out_valid,
  input  logic                       out_ready,
  output prep_t                      out_data
);

  typedef struct packed {
    logic [2:0][NUM_W-1:0] num;
    logic [2:0][DEN_W-1:0] den;
  } wgt_t;

  typedef struct packed {
    wgt_t                w;
    logic [SAMPLE_W-1:0] a;
    logic [SAMPLE_W-1:0] b;
  } st1_t;

  localparam logic signed [NUM_W-1:0] CQ_S = NUM_W'(CQ);

  function automatic logic [NUM_W-1:0] abs_diff(input logic signed [NUM_W-1:0] p,
                                                input logic signed [NUM_W-1:0] q);
    logic signed [NUM_W-1:0] d;
    d = p - q;
    return d[NUM_W-1] ? NUM_W'(-d) : d;
  endfunction

  // {num, den} of (range - offset) / range, den never zero
  function automatic logic [NUM_W+DEN_W-1:0] weight(input logic signed [NUM_W-1:0] rng,
                                                    input logic [NUM_W-1:0] offset);
    logic signed [NUM_W:0] n;
    logic signed [NUM_W:0] dd;
    n  = $signed({rng[NUM_W-1], rng}) - $signed({1'b0, offset});
    dd = $signed({rng[NUM_W-1], rng});
    if (rng < 0) begin
      n  = -n;
      dd = -dd;
    end
    if (dd == 0 || n <= 0) begin
      return {NUM_W'(0), DEN_W'(1)};
    end
    return {n[NUM_W-1:0], dd[DEN_W-1:0]};
  endfunction

  localparam logic [NUM_W+DEN_W-1:0] W_ONE = {NUM_W'(1), DEN_W'(1)};

  logic signed [NUM_W-1:0] s_e, low_e, mid_e, high_e, rl, rh, rm;
  logic [NUM_W+DEN_W-1:0]  wl, wm, wh;
  st1_t                    st1_nxt, st1_r;
  prep_t                   st2_nxt, st2_r;
  logic                    v1_r, v2_r, rdy1, rdy2;
  logic [2:0][COLOR_W-1:0] col;

  assign s_e    = {in_sample[SAMPLE_W-1], in_sample};
  assign low_e  = {cfg.border_low[SAMPLE_W-1], cfg.border_low};
  assign mid_e  = {cfg.border_mid[SAMPLE_W-1], cfg.border_mid};
  assign high_e = {cfg.border_high[SAMPLE_W-1], cfg.border_high};
  assign rl     = mid_e - low_e;
  assign rh     = high_e - mid_e;
  assign rm     = (rl > rh) ? rl : rh;

  always_comb begin
    wl = (s_e <= low_e) ? W_ONE : weight(rl, abs_diff(s_e, low_e));
    wm = weight(rm, abs_diff(s_e, mid_e));
    wh = (s_e >= high_e) ? W_ONE : weight(rh, abs_diff(s_e, high_e));
    st1_nxt.w.num[0] = wl[NUM_W+DEN_W-1:DEN_W];
    st1_nxt.w.den[0] = wl[DEN_W-1:0];
    st1_nxt.w.num[1] = wm[NUM_W+DEN_W-1:DEN_W];
    st1_nxt.w.den[1] = wm[DEN_W-1:0];
    st1_nxt.w.num[2] = wh[NUM_W+DEN_W-1:DEN_W];
    st1_nxt.w.den[2] = wh[DEN_W-1:0];
    st1_nxt.a = SAMPLE_W'(abs_diff(s_e, CQ_S));
    st1_nxt.b = SAMPLE_W'(abs_diff(s_e, -CQ_S));
  end

  assign col[0] = cfg.color_low;
  assign col[1] = cfg.color_mid;
  assign col[2] = cfg.color_high;

  always_comb begin
    logic [DIVD_W-2:0] pr;
    for (int j = 0; j < 3; j++) begin
      for (int c = 0; c < 3; c++) begin
        pr = st1_r.w.num[j] * col[j][(2-c)*8 +: 8];
        st2_nxt.x[j][c] = {pr, 1'b0} + DIVD_W'(st1_r.w.den[j]);
      end
      st2_nxt.y[j] = {st1_r.w.den[j], 1'b0};
    end
    st2_nxt.a2 = RAD_W'(st1_r.a) * RAD_W'(st1_r.a);
    st2_nxt.b2 = RAD_W'(st1_r.b) * RAD_W'(st1_r.b);
  end

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) st1_r <= st1_nxt;
    if (rdy2 && v1_r) st2_r <= st2_nxt;
  end

  assign out_valid = v2_r;
  assign out_data  = st2_r;

endmodule

`default_nettype wire

// File: design/cbm_core.sv
// pipelined restoring dividers for the nine color terms and the distance square root
// depends on cbm_pkg
`default_nettype none

module cbm_core import cbm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  prep_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output core_t out_data
);

  function automatic core_t core_step(input core_t c, input logic sq_on);
    core_t               o;
    logic [DIVS_W:0]     rs;
    logic [SREM_W-1:0]   t;
    logic [SREM_W-1:0]   tr;
    o = c;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        rs = {c.rem[j][k], c.xs[j][k][DIVD_W-1]};
        if (rs >= {1'b0, c.y[j]}) begin
          o.rem[j][k] = DIVS_W'(rs - {1'b0, c.y[j]});
          o.q[j][k]   = {c.q[j][k][Q_W-2:0], 1'b1};
        end else begin
          o.rem[j][k] = rs[DIVS_W-1:0];
          o.q[j][k]   = {c.q[j][k][Q_W-2:0], 1'b0};
        end
        o.xs[j][k] = {c.xs[j][k][DIVD_W-2:0], 1'b0};
      end
    end
    if (sq_on) begin
      t  = {c.srem[SREM_W-3:0], c.vs[RAD_W-1 -: 2]};
      tr = SREM_W'({c.root, 2'b01});
      if (t >= tr) begin
        o.srem = t - tr;
        o.root = {c.root[ROOT_W-2:0], 1'b1};
      end else begin
        o.srem = t;
        o.root = {c.root[ROOT_W-2:0], 1'b0};
      end
      o.vs = {c.vs[RAD_W-3:0], 2'b00};
    end
    return o;
  endfunction

  core_t                entry;
  core_t                stg_in  [CORE_STG];
  core_t                stg_dat [CORE_STG];
  logic [CORE_STG-1:0]  stg_vin;
  logic [CORE_STG-1:0]  stg_vld;
  logic [CORE_STG:0]    rdy;

  always_comb begin
    entry.xs   = in_data.x;
    entry.rem  = '0;
    entry.q    = '0;
    entry.y    = in_data.y;
    entry.vs   = in_data.a2 + in_data.b2;
    entry.srem = '0;
    entry.root = '0;
  end

  assign rdy[CORE_STG] = out_ready;

  for (genvar k = 0; k < CORE_STG; k++) begin : g_stg
    localparam logic SQ_ON = (k < SQRT_STG) ? 1'b1 : 1'b0;
    logic  vld_r;
    core_t dat_r;
    core_t dat_nxt;

    if (k == 0) begin : g_first
      assign stg_in[k]  = entry;
      assign stg_vin[k] = in_valid;
    end else begin : g_next
      assign stg_in[k]  = stg_dat[k-1];
      assign stg_vin[k] = stg_vld[k-1];
    end

    assign rdy[k] = !vld_r || rdy[k+1];

    always_comb begin
      dat_nxt = stg_in[k];
      for (int i = 0; i < STEPS_PER_STG; i++) begin
        dat_nxt = core_step(dat_nxt, SQ_ON);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (rdy[k]) begin
        vld_r <= stg_vin[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && stg_vin[k]) dat_r <= dat_nxt;
    end

    assign stg_vld[k] = vld_r;
    assign stg_dat[k] = dat_r;
  end

  assign in_ready  = rdy[0];
  assign out_valid = stg_vld[CORE_STG-1];
  assign out_data  = stg_dat[CORE_STG-1];

endmodule

`default_nettype wire

// File: design/cbm_post.sv
// back stages: channel sums, distance falloff and gray level
// depends on cbm_pkg
`default_nettype none

module cbm_post import cbm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  core_t in_data,
  input  logic  bump_enable,
  output logic  out_valid,
  input  logic  out_ready,
  output pix_t  out_data
);

  typedef struct packed {
    logic [2:0][7:0] rgb;
    logic [P_W-1:0]  p;
  } sta_t;

  typedef struct packed {
    logic [2:0][7:0]   rgb;
    logic [PROD_W-1:0] prod;
  } stb_t;

  localparam logic [P_W-1:0]    KQ_P    = P_W'(KQ);
  localparam logic [P_W-1:0]    ONE2_P  = P_W'(ONE2);
  localparam logic [PROD_W-1:0] HALF3_P = PROD_W'(HALF3);

  sta_t              a_nxt, a_r;
  stb_t              b_nxt, b_r;
  pix_t              c_nxt, c_r;
  logic              va_r, vb_r, vc_r, rdya, rdyb, rdyc;
  logic [SUM_W-1:0]  sum;
  logic [G_W-1:0]    gf;
  logic [PROD_W-1:0] tsum;
  logic [T_W-1:0]    t;
  logic [M_W-1:0]    m;

  // stage a: wrap each channel, scale the distance
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      a_nxt.rgb[c] = in_data.q[0][c] + in_data.q[1][c] + in_data.q[2][c];
    end
    a_nxt.p = KQ_P * P_W'(in_data.root);
  end

  // stage b: falloff times channel total
  always_comb begin
    sum = SUM_W'(a_r.rgb[0]) + SUM_W'(a_r.rgb[1]) + SUM_W'(a_r.rgb[2]);
    gf  = (a_r.p >= ONE2_P) ? '0 : G_W'(ONE2_P - a_r.p);
    b_nxt.rgb  = a_r.rgb;
    b_nxt.prod = PROD_W'(gf) * PROD_W'(sum);
  end

  // stage c: round by 2^2F, then divide by three through the reciprocal
  always_comb begin
    tsum = b_r.prod + HALF3_P;
    t    = T_W'(tsum >> (2 * FRAC_BITS));
    m    = M_W'(t) * M_W'(RECIP3);
    c_nxt.red   = b_r.rgb[0];
    c_nxt.green = b_r.rgb[1];
    c_nxt.blue  = b_r.rgb[2];
    c_nxt.gray  = bump_enable ? m[RECIP_SH +: 8] : 8'd0;
  end

  assign rdyc     = !vc_r || out_ready;
  assign rdyb     = !vb_r || rdyc;
  assign rdya     = !va_r || rdyb;
  assign in_ready = rdya;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdya) va_r <= in_valid;
      if (rdyb) vb_r <= va_r;
      if (rdyc) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdya && in_valid) a_r <= a_nxt;
    if (rdyb && va_r) b_r <= b_nxt;
    if (rdyc && vb_r) c_r <= c_nxt;
  end

  assign out_valid = vc_r;
  assign out_data  = c_r;

endmodule

`default_nettype wire

// File: design/three_border_color_map.sv
// top level of the three border color map: configuration registers and pipeline
// depends on cbm_pkg, cbm_stream_if, cbm_prep, cbm_core, cbm_post and the macro header
`default_nettype none
`include "three_border_color_map_macros.svh"

// Maps one signed Q1.14 noise sample per transfer to an RGB pixel blended from
// three colors placed at three borders, plus a gray bump-map level. One sample
// enters every clock cycle while the pixel output is not held; a pixel leaves
// after 2 front, 13 divider and 3 back stages. The depth is set by the
// 26 bit dividends of the rounded color terms, worked two quotient bits per
// stage; the distance square root runs alongside in the first 8 of those stages.
// Every stage has its own valid bit and stalls only when the stage behind it is
// full, so bubbles close up while the pixel output is held. Registers are
// written with cfg_we, cfg_index and cfg_data and must only change while no
// sample is in flight.
module three_border_color_map import cbm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  cbm_in_if.sink                in_ch,
  cbm_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg_r;

  // handshake between the pipeline parts
  logic  prep_vld, prep_rdy;
  prep_t prep_dat;
  logic  core_vld, core_rdy;
  core_t core_dat;
  logic  post_rdy_in;
  pix_t  pix;

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BORDER_LOW:  cfg_r.border_low  <= cfg_data[SAMPLE_W-1:0];
        CFG_BORDER_MID:  cfg_r.border_mid  <= cfg_data[SAMPLE_W-1:0];
        CFG_BORDER_HIGH: cfg_r.border_high <= cfg_data[SAMPLE_W-1:0];
        CFG_COLOR_LOW:   cfg_r.color_low   <= cfg_data[COLOR_W-1:0];
        CFG_COLOR_MID:   cfg_r.color_mid   <= cfg_data[COLOR_W-1:0];
        CFG_COLOR_HIGH:  cfg_r.color_high  <= cfg_data[COLOR_W-1:0];
        CFG_BUMP_ENABLE: cfg_r.bump_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // weights and dividends
  cbm_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_sample (in_ch.noise_sample),
    .cfg       (cfg_r),
    .out_valid (prep_vld),
    .out_ready (prep_rdy),
    .out_data  (prep_dat)
  );

  // long division of every color term and the distance root
  cbm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prep_vld),
    .in_ready  (prep_rdy),
    .in_data   (prep_dat),
    .out_valid (core_vld),
    .out_ready (core_rdy),
    .out_data  (core_dat)
  );

  // channel sums and gray, last stage is the output register
  cbm_post u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (core_vld),
    .in_ready    (post_rdy_in),
    .in_data     (core_dat),
    .bump_enable (cfg_r.bump_enable),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_data    (pix)
  );

  assign core_rdy     = post_rdy_in;
  assign out_ch.red   = pix.red;
  assign out_ch.green = pix.green;
  assign out_ch.blue  = pix.blue;
  assign out_ch.gray  = pix.gray;

  // back pressure at the input only when every stage up to the output is full
  `CBM_ASSERT(a_stall_from_output, !in_ch.ready |-> (out_ch.valid && !out_ch.ready), "input stalled without a held pixel")

  // every divider gets a nonzero divisor
  `CBM_NEVER(a_divisor_zero, prep_vld && (prep_dat.y[0] == '0 || prep_dat.y[1] == '0 || prep_dat.y[2] == '0), "zero divisor entered the divider")

  // the core output only holds when the back stages refuse it
  `CBM_ASSERT(a_core_hold, (core_vld && !core_rdy) |-> !post_rdy_in, "core output held while back stages ready")

endmodule

`default_nettype wire
